@@ design/vmvs_pkg.sv @@
package vmvs_pkg;

  // Stack geometry
  localparam int DEPTH = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int TOP_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int CMD_W = 3;
  localparam int IDX_W = 12;
  localparam int TO_W = 10;
  localparam int TAG_W = 4;
  localparam int DATA_W = 64;
  localparam int STAT_W = 2;
  localparam int DEPTH_NOW_W = 11;

  // Signed width for index arithmetic: holds index, stack top and DEPTH
  localparam int RES_W = ((TOP_W > IDX_W) ? TOP_W : IDX_W) + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 3'd0,
    CMD_POP  = 3'd1,
    CMD_GET  = 3'd2,
    CMD_SET  = 3'd3,
    CMD_REV  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_OVER   = 2'd1,
    ST_UNDER  = 2'd2,
    ST_BADIDX = 2'd3
  } stat_code_t;

  typedef enum logic [0:0] {
    REG_NIL_TAG  = 1'b0,
    REG_NONE_TAG = 1'b1
  } cfg_reg_t;

  // One stack slot as stored in memory; written is low until first write
  typedef struct packed {
    logic              written;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } slot_t;

  typedef enum logic [2:0] {
    WR_CLR    = 3'd0,
    WR_PUSH   = 3'd1,
    WR_POP    = 3'd2,
    WR_SET    = 3'd3,
    WR_REV_LO = 3'd4,
    WR_REV_HI = 3'd5
  } wr_sel_t;

  typedef enum logic [1:0] {
    RD_POP = 2'd0,
    RD_GET = 2'd1,
    RD_LO  = 2'd2,
    RD_HI  = 2'd3
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    take;
    logic    exec;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    save_lo;
    logic    rev_step;
    logic    clr_step;
    logic    out_load;
  } ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             ok;
    logic             rev_more;
    logic             clr_last;
  } dp_stat_t;

endpackage

@@ design/vm_value_stack_relative_index.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  cmd, index, index_to, value_tag, value_data
// out      output     out_valid / out_stall out_tag, out_data, status, depth_now
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Push, get, set and every error go through S_EXEC to S_RESP; pop adds S_POP_WB.
// Reverse walks the range pair by pair: each pair is two reads and two writes
// through the one write port and one read port of the slot memory.
// After reset a clearing pass marks every slot unwritten; no item
// is taken during it, configuration writes are.
// A new item is taken while a result waits under out_stall; the next result waits.
module vm_value_stack_relative_index import vmvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [IDX_W-1:0] index,
  input  logic [TO_W-1:0]         index_to,
  input  logic [TAG_W-1:0]        value_tag,
  input  logic [DATA_W-1:0]       value_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [TAG_W-1:0]        out_tag,
  output logic [DATA_W-1:0]       out_data,
  output logic [STAT_W-1:0]       status,
  output logic [DEPTH_NOW_W-1:0]  depth_now,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [TAG_W-1:0]        cfg_data
);

  ctl_t     ctl;
  dp_stat_t dp_stat;

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;

  vmvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_stat   (dp_stat),
    .ctl       (ctl)
  );

  vmvs_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .dp_stat    (dp_stat),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .index      (index),
    .index_to   (index_to),
    .value_tag  (value_tag),
    .value_data (value_data),
    .out_tag    (out_tag),
    .out_data   (out_data),
    .status     (status),
    .depth_now  (depth_now)
  );

endmodule

@@ design/vmvs_ctrl.sv @@
module vmvs_ctrl import vmvs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t dp_stat,
  output ctl_t     ctl
);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_EXEC    = 9'b000000100,
    S_POP_WB  = 9'b000001000,
    S_REV_LO  = 9'b000010000,
    S_REV_HI  = 9'b000100000,
    S_REV_WLO = 9'b001000000,
    S_REV_WHI = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl = '0;
    ctl.wr_sel = WR_CLR;
    ctl.rd_sel = RD_POP;
    unique case (state)
      S_CLEAR: begin
        ctl.wr_en = 1'b1;
        ctl.wr_sel = WR_CLR;
        ctl.clr_step = 1'b1;
        if (dp_stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.take = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        state_next = S_RESP;
        unique case (dp_stat.op)
          CMD_PUSH: begin
            ctl.wr_en = dp_stat.ok;
            ctl.wr_sel = WR_PUSH;
          end
          CMD_POP: begin
            ctl.rd_en = dp_stat.ok;
            ctl.rd_sel = RD_POP;
            if (dp_stat.ok) state_next = S_POP_WB;
          end
          CMD_GET: begin
            ctl.rd_en = dp_stat.ok;
            ctl.rd_sel = RD_GET;
          end
          CMD_SET: begin
            ctl.wr_en = dp_stat.ok;
            ctl.wr_sel = WR_SET;
          end
          CMD_REV: begin
            if (dp_stat.ok) state_next = S_REV_LO;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_POP_WB: begin
        ctl.wr_en = 1'b1;
        ctl.wr_sel = WR_POP;
        state_next = S_RESP;
      end
      S_REV_LO: begin
        if (dp_stat.rev_more) begin
          ctl.rd_en = 1'b1;
          ctl.rd_sel = RD_LO;
          state_next = S_REV_HI;
        end else begin
          state_next = S_RESP;
        end
      end
      S_REV_HI: begin
        ctl.rd_en = 1'b1;
        ctl.rd_sel = RD_HI;
        ctl.save_lo = 1'b1;
        state_next = S_REV_WLO;
      end
      S_REV_WLO: begin
        ctl.wr_en = 1'b1;
        ctl.wr_sel = WR_REV_LO;
        state_next = S_REV_WHI;
      end
      S_REV_WHI: begin
        ctl.wr_en = 1'b1;
        ctl.wr_sel = WR_REV_HI;
        ctl.rev_step = 1'b1;
        state_next = S_REV_LO;
      end
      S_RESP: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Hold result valid until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ design/vmvs_dp.sv @@
module vmvs_dp import vmvs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  ctl_t                   ctl,
  output dp_stat_t               dp_stat,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [TAG_W-1:0]       cfg_data,
  input  logic [CMD_W-1:0]       cmd,
  input  logic signed [IDX_W-1:0] index,
  input  logic [TO_W-1:0]        index_to,
  input  logic [TAG_W-1:0]       value_tag,
  input  logic [DATA_W-1:0]      value_data,
  output logic [TAG_W-1:0]       out_tag,
  output logic [DATA_W-1:0]      out_data,
  output logic [STAT_W-1:0]      status,
  output logic [DEPTH_NOW_W-1:0] depth_now
);

  // Configuration registers
  logic [TAG_W-1:0] nil_tag;
  logic [TAG_W-1:0] none_tag;

  // Item held for the command in flight
  logic [CMD_W-1:0]        cmd_q;
  logic signed [IDX_W-1:0] index_q;
  logic [TO_W-1:0]         index_to_q;
  logic [TAG_W-1:0]        vtag_q;
  logic [DATA_W-1:0]       vdata_q;

  // Stack state and walk pointers
  logic [TOP_W-1:0]  top;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic [ADDR_W-1:0] clr_addr;
  slot_t             save;

  // Result bookkeeping
  logic [STAT_W-1:0] res_status;
  logic              res_val;

  // Slot memory
  slot_t             mem [DEPTH];
  slot_t             rd_q;
  slot_t             wr_word;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // Index resolution
  logic signed [RES_W-1:0] idx_x;
  logic signed [RES_W-1:0] top_x;
  logic signed [RES_W-1:0] to_x;
  logic signed [RES_W-1:0] abs_pos;
  logic [ADDR_W-1:0]       pos;
  logic                    idx_ok;
  logic                    rev_bad;
  logic                    full;
  logic                    empty;
  logic [STAT_W-1:0]       exec_status;
  logic [TAG_W-1:0]        rd_tag;
  logic [DATA_W-1:0]       rd_data;

  always_comb begin
    idx_x = RES_W'(index_q);
    top_x = RES_W'(top);
    to_x = RES_W'(index_to_q);
    abs_pos = idx_x[RES_W-1] ? (idx_x + top_x + RES_W'(1)) : idx_x;
    idx_ok = (abs_pos >= RES_W'(1)) && (abs_pos <= top_x);
    pos = ADDR_W'(abs_pos - RES_W'(1));
    rev_bad = idx_x[RES_W-1] || (idx_x >= RES_W'(DEPTH)) || (to_x >= RES_W'(DEPTH));
    full = (top >= TOP_W'(DEPTH));
    empty = (top == '0);
  end

  // Status for the held command
  always_comb begin
    unique case (cmd_q)
      CMD_PUSH: exec_status = full ? ST_OVER : ST_OK;
      CMD_POP:  exec_status = empty ? ST_UNDER : ST_OK;
      CMD_GET:  exec_status = idx_ok ? ST_OK : ST_BADIDX;
      CMD_SET:  exec_status = idx_ok ? ST_OK : ST_BADIDX;
      CMD_REV:  exec_status = rev_bad ? ST_BADIDX : ST_OK;
      default:  exec_status = ST_OK;
    endcase
  end

  assign dp_stat.op = cmd_q;
  assign dp_stat.ok = (exec_status == ST_OK);
  assign dp_stat.rev_more = (lo < hi);
  assign dp_stat.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));

  // Unwritten slots read as the current none tag with zero payload
  assign rd_tag = rd_q.written ? rd_q.tag : none_tag;
  assign rd_data = rd_q.written ? rd_q.data : '0;

  // Select memory write address and word
  always_comb begin
    wr_addr = clr_addr;
    wr_word = '0;
    unique case (ctl.wr_sel)
      WR_CLR: begin
        wr_addr = clr_addr;
        wr_word = '0;
      end
      WR_PUSH: begin
        wr_addr = ADDR_W'(top);
        wr_word = {1'b1, vtag_q, vdata_q};
      end
      WR_POP: begin
        wr_addr = ADDR_W'(top);
        wr_word = {1'b1, nil_tag, rd_data};
      end
      WR_SET: begin
        wr_addr = pos;
        wr_word = {1'b1, vtag_q, vdata_q};
      end
      WR_REV_LO: begin
        wr_addr = lo;
        wr_word = rd_q;
      end
      WR_REV_HI: begin
        wr_addr = hi;
        wr_word = save;
      end
      default: begin
        wr_addr = clr_addr;
        wr_word = '0;
      end
    endcase
  end

  // Select memory read address
  always_comb begin
    unique case (ctl.rd_sel)
      RD_POP:  rd_addr = ADDR_W'(top - TOP_W'(1));
      RD_GET:  rd_addr = pos;
      RD_LO:   rd_addr = lo;
      RD_HI:   rd_addr = hi;
      default: rd_addr = lo;
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nil_tag <= '0;
      none_tag <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NIL_TAG:  nil_tag <= cfg_data;
        REG_NONE_TAG: none_tag <= cfg_data;
        default:      nil_tag <= nil_tag;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q <= cmd;
      index_q <= index;
      index_to_q <= index_to;
      vtag_q <= value_tag;
      vdata_q <= value_data;
    end
  end

  // Stack top and clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      clr_addr <= '0;
    end else begin
      if (ctl.clr_step) clr_addr <= clr_addr + ADDR_W'(1);
      if (ctl.exec && dp_stat.ok) begin
        if (cmd_q == CMD_PUSH) top <= top + TOP_W'(1);
        else if (cmd_q == CMD_POP) top <= top - TOP_W'(1);
      end
    end
  end

  // Result status, reverse pointers and saved low slot
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_status <= exec_status;
      res_val <= dp_stat.ok && ((cmd_q == CMD_POP) || (cmd_q == CMD_GET));
      lo <= ADDR_W'(index_q);
      hi <= ADDR_W'(index_to_q);
    end else if (ctl.rev_step) begin
      lo <= lo + ADDR_W'(1);
      hi <= hi - ADDR_W'(1);
    end
    if (ctl.save_lo) save <= rd_q;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_tag <= res_val ? rd_tag : '0;
      out_data <= res_val ? rd_data : '0;
      status <= res_status;
      depth_now <= DEPTH_NOW_W'(top);
    end
  end

endmodule

@@ bench/stack_result_check.sv @@
module stack_result_check import vmvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [IDX_W-1:0] index,
  input  logic [TO_W-1:0]         index_to,
  input  logic [TAG_W-1:0]        value_tag,
  input  logic [DATA_W-1:0]       value_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [TAG_W-1:0]        out_tag,
  input  logic [DATA_W-1:0]       out_data,
  input  logic [STAT_W-1:0]       status,
  input  logic [DEPTH_NOW_W-1:0]  depth_now,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [TAG_W-1:0]        cfg_data,
  output int                      mismatches,
  output int                      pending
);

  typedef struct packed {
    logic [TAG_W-1:0]       tag;
    logic [DATA_W-1:0]      data;
    logic [STAT_W-1:0]      st;
    logic [DEPTH_NOW_W-1:0] depth;
  } stack_result_t;

  // Shadow of the slot memory, the stack top and the tag registers
  logic [TAG_W-1:0]  slot_tag  [DEPTH];
  logic [DATA_W-1:0] slot_data [DEPTH];
  bit                slot_live [DEPTH];
  int                depth_count;
  logic [TAG_W-1:0]  nil_code;
  logic [TAG_W-1:0]  none_code;
  stack_result_t     expected_results[$];

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    mismatches++;
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  // Unwritten slots read as the current none tag with zero payload
  function automatic logic [TAG_W+DATA_W-1:0] read_value(input int pos);
    if (slot_live[pos]) begin
      return {slot_tag[pos], slot_data[pos]};
    end
    return {none_code, {DATA_W{1'b0}}};
  endfunction

  // Map a 1-based index, negative from the top, to a slot; -1 when out of range
  function automatic int slot_of(input int idx);
    int a;
    a = (idx >= 0) ? idx : idx + depth_count + 1;
    return (a < 1 || a > depth_count) ? -1 : a - 1;
  endfunction

  // Apply one command to the shadow and queue the result it must give
  task automatic predict_command();
    stack_result_t     r;
    int                idx;
    int                pos;
    int                lo;
    int                hi;
    logic [TAG_W-1:0]  t;
    logic [DATA_W-1:0] d;
    bit                w;
    r = '0;
    r.st = ST_OK;
    idx = int'(index);
    case (cmd)
      CMD_PUSH: begin
        if (depth_count >= DEPTH) begin
          r.st = ST_OVER;
        end else begin
          slot_tag[depth_count] = value_tag;
          slot_data[depth_count] = value_data;
          slot_live[depth_count] = 1'b1;
          depth_count++;
        end
      end
      CMD_POP: begin
        if (depth_count == 0) begin
          r.st = ST_UNDER;
        end else begin
          depth_count--;
          {r.tag, r.data} = read_value(depth_count);
          slot_tag[depth_count] = nil_code;
          if (!slot_live[depth_count]) begin
            slot_data[depth_count] = '0;
            slot_live[depth_count] = 1'b1;
          end
        end
      end
      CMD_GET: begin
        pos = slot_of(idx);
        if (pos < 0) begin
          r.st = ST_BADIDX;
        end else begin
          {r.tag, r.data} = read_value(pos);
        end
      end
      CMD_SET: begin
        pos = slot_of(idx);
        if (pos < 0) begin
          r.st = ST_BADIDX;
        end else begin
          slot_tag[pos] = value_tag;
          slot_data[pos] = value_data;
          slot_live[pos] = 1'b1;
        end
      end
      CMD_REV: begin
        if (idx < 0 || idx >= DEPTH || int'(index_to) >= DEPTH) begin
          r.st = ST_BADIDX;
        end else begin
          // swap raw slots pairwise, written marks included, top ignored
          lo = idx;
          hi = int'(index_to);
          while (lo < hi) begin
            t = slot_tag[lo];
            d = slot_data[lo];
            w = slot_live[lo];
            slot_tag[lo] = slot_tag[hi];
            slot_data[lo] = slot_data[hi];
            slot_live[lo] = slot_live[hi];
            slot_tag[hi] = t;
            slot_data[hi] = d;
            slot_live[hi] = w;
            lo++;
            hi--;
          end
        end
      end
      default: begin
        // unknown commands leave everything alone
      end
    endcase
    r.depth = DEPTH_NOW_W'(depth_count);
    expected_results.push_back(r);
  endtask

  // Compare one result transfer with the oldest expectation
  task automatic check_result();
    stack_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", out_data, '0);
    end else begin
      want = expected_results.pop_front();
      if (out_tag !== want.tag) begin
        report_mismatch("out_tag", DATA_W'(out_tag), DATA_W'(want.tag));
      end
      if (out_data !== want.data) report_mismatch("out_data", out_data, want.data);
      if (status !== want.st) begin
        report_mismatch("status", DATA_W'(status), DATA_W'(want.st));
      end
      if (depth_now !== want.depth) begin
        report_mismatch("depth_now", DATA_W'(depth_now), DATA_W'(want.depth));
      end
    end
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slot_tag[i] = 4'hF;
        slot_data[i] = '0;
        slot_live[i] = 1'b0;
      end
      depth_count = 0;
      nil_code = 4'h0;
      none_code = 4'hF;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_NIL_TAG) nil_code = cfg_data;
        else none_code = cfg_data;
      end
      if (in_valid && !in_stall) predict_command();
    end
    pending <= expected_results.size();
  end

endmodule

@@ bench/tb_vm_value_stack_relative_index.sv @@
module tb_vm_value_stack_relative_index;
  import vmvs_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  wire                     in_stall;
  logic [CMD_W-1:0]        cmd = '0;
  logic signed [IDX_W-1:0] index = '0;
  logic [TO_W-1:0]         index_to = '0;
  logic [TAG_W-1:0]        value_tag = '0;
  logic [DATA_W-1:0]       value_data = '0;
  wire                     out_valid;
  logic                    out_stall = 1'b0;
  wire [TAG_W-1:0]         out_tag;
  wire [DATA_W-1:0]        out_data;
  wire [STAT_W-1:0]        status;
  wire [DEPTH_NOW_W-1:0]   depth_now;
  logic                    cfg_valid = 1'b0;
  wire                     cfg_ready;
  logic                    cfg_index = 1'b0;
  logic [TAG_W-1:0]        cfg_data = '0;

  int mismatches;
  int pending;
  int level = 0;
  int items_sent = 0;
  int results_seen = 0;
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  vm_value_stack_relative_index dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .index(index), .index_to(index_to),
    .value_tag(value_tag), .value_data(value_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tag(out_tag), .out_data(out_data), .status(status), .depth_now(depth_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  stack_result_check u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .index(index), .index_to(index_to),
    .value_tag(value_tag), .value_data(value_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_tag(out_tag), .out_data(out_data), .status(status), .depth_now(depth_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  // Hold off the result side for a random count before each transfer
  initial begin
    @(posedge clk);
    forever begin : stall_results
      int hold;
      if (results_seen % 40 == 0) out_gaps_on = ($urandom_range(0, 3) != 0);
      hold = out_gaps_on ? int'($urandom_range(0, 13)) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
    end
  end

  // Present one command after a random gap and hold it until the transfer
  task automatic send_item(input logic [CMD_W-1:0] c, input int idx, input int stop_at,
                           input logic [TAG_W-1:0] tag, input logic [DATA_W-1:0] data);
    int gap;
    if (items_sent % 40 == 0) in_gaps_on = ($urandom_range(0, 3) != 0);
    gap = in_gaps_on ? int'($urandom_range(0, 13)) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    index <= IDX_W'(idx);
    index_to <= TO_W'(stop_at);
    value_tag <= tag;
    value_data <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (c == CMD_PUSH && level < DEPTH) level++;
    if (c == CMD_POP && level > 0) level--;
  endtask

  // Drop valid, wait for every result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both tag registers back to back while the block is idle
  task automatic set_tags(input logic [TAG_W-1:0] nil_v, input logic [TAG_W-1:0] none_v);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NIL_TAG;
    cfg_data <= nil_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_NONE_TAG;
    cfg_data <= none_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-range indexes from either end, the rest out of range
  function automatic int stack_index();
    int r;
    r = $urandom_range(0, 9);
    if (level > 0 && r < 4) return $urandom_range(1, level);
    if (level > 0 && r < 8) return -int'($urandom_range(1, level));
    case ($urandom_range(0, 4))
      0: return 0;
      1: return level + 1;
      2: return -(level + 1);
      3: return -int'($urandom_range(level + 1, 2048));
      default: return $urandom_range(level + 1, 2047);
    endcase
  endfunction

  // One random command; weights steer the stack up or down
  task automatic random_item(input int push_w, input int pop_w);
    int pick;
    int idx;
    int stop_at;
    logic [CMD_W-1:0] c;
    pick = $urandom_range(0, push_w + pop_w + 42);
    idx = int'($urandom_range(0, 4095)) - 2048;
    stop_at = $urandom_range(0, 1023);
    if (pick < push_w) begin
      c = CMD_PUSH;
    end else if (pick < push_w + pop_w) begin
      c = CMD_POP;
    end else if (pick < push_w + pop_w + 20) begin
      c = CMD_GET;
      idx = stack_index();
    end else if (pick < push_w + pop_w + 35) begin
      c = CMD_SET;
      idx = stack_index();
    end else if (pick < push_w + pop_w + 41) begin
      c = CMD_REV;
      case ($urandom_range(0, 19))
        0: begin
          // long walk across nearly the whole memory
          idx = $urandom_range(0, 15);
          stop_at = $urandom_range(1008, 1023);
        end
        1: idx = -int'($urandom_range(1, 2048));
        2: idx = $urandom_range(DEPTH, 2047);
        default: begin
          // short range around the top, sometimes empty
          idx = $urandom_range(0, (level + 16 < DEPTH) ? level + 16 : DEPTH - 1);
          stop_at = idx + int'($urandom_range(0, 12)) - 2;
          if (stop_at < 0) stop_at = 0;
          if (stop_at >= DEPTH) stop_at = DEPTH - 1;
        end
      endcase
    end else begin
      c = 3'(CMD_REV) + 3'($urandom_range(1, 3));
    end
    send_item(c, idx, stop_at, TAG_W'($urandom_range(0, 15)), {$urandom, $urandom});
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty stack: underflow and bad indexes
    send_item(CMD_POP, 0, 0, '0, '0);
    send_item(CMD_GET, 1, 0, '0, '0);
    send_item(CMD_SET, -1, 0, 4'h6, 64'h1234);
    // Extremes of the value fields
    send_item(CMD_PUSH, 0, 0, 4'h0, '0);
    send_item(CMD_PUSH, 0, 0, 4'hF, '1);
    send_item(CMD_PUSH, 0, 0, 4'hA, 64'h8000_0000_0000_0001);
    // Positive and negative indexes, in and out of range
    send_item(CMD_GET, 1, 0, '0, '0);
    send_item(CMD_GET, -1, 0, '0, '0);
    send_item(CMD_GET, 4, 0, '0, '0);
    send_item(CMD_GET, -4, 0, '0, '0);
    send_item(CMD_GET, 0, 0, '0, '0);
    send_item(CMD_SET, 2, 0, 4'h3, 64'hDEAD_BEEF_0BAD_F00D);
    send_item(CMD_GET, -2, 0, '0, '0);
    send_item(CMD_GET, 2047, 0, '0, '0);
    send_item(CMD_GET, -2048, 0, '0, '0);
    // Swap unwritten slots under the top, then read and pop them
    send_item(CMD_REV, 0, 9, '0, '0);
    send_item(CMD_GET, 1, 0, '0, '0);
    send_item(CMD_POP, 0, 0, '0, '0);
    // Empty range, bad ranges and a short valid range
    send_item(CMD_REV, 5, 3, '0, '0);
    send_item(CMD_REV, -1, 5, '0, '0);
    send_item(CMD_REV, DEPTH, 5, '0, '0);
    send_item(CMD_REV, 2047, 5, '0, '0);
    send_item(CMD_REV, 7, 9, '0, '0);
    // Unknown commands
    send_item(3'(CMD_REV) + 3'd1, 0, 0, '0, '0);
    send_item(3'(CMD_REV) + 3'd3, 0, 0, '0, '0);
    settle();

    set_tags(4'hF, 4'h0);
    repeat (20) random_item(30, 25);
    settle();

    set_tags(4'h9, 4'h6);
    repeat (20) random_item(30, 25);
    settle();

    // Fill to the limit, then overflow and address the full stack
    set_tags(4'h5, 4'hA);
    while (level < DEPTH) random_item(6000, 5);
    send_item(CMD_PUSH, 0, 0, 4'h1, 64'h55);
    send_item(CMD_PUSH, 0, 0, 4'h2, 64'hAA);
    send_item(CMD_GET, DEPTH, 0, '0, '0);
    send_item(CMD_GET, -DEPTH, 0, '0, '0);
    send_item(CMD_SET, -DEPTH, 0, 4'hC, 64'h0F0F);
    send_item(CMD_GET, DEPTH + 1, 0, '0, '0);
    send_item(CMD_REV, 0, DEPTH - 1, '0, '0);
    send_item(CMD_GET, 1, 0, '0, '0);
    settle();

    set_tags(4'h0, 4'h0);
    repeat (20) random_item(10, 120);
    settle();

    set_tags(4'hF, 4'hF);
    repeat (20) random_item(30, 25);
    settle();

    if (mismatches == 0) begin
      $display("tb_vm_value_stack_relative_index: PASS");
    end else begin
      $display("tb_vm_value_stack_relative_index: FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest passing run
  initial begin
    #4000000;
    $display("tb_vm_value_stack_relative_index: FAIL");
    $finish;
  end

endmodule
